/* hdl/sync_length_frame_deframer_unit_macros.svh */
// assertion macros for the deframer
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SLFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");
// next-cycle implication
`define SLFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define SLFD_ASSERT_NOW(label, clk, rstn, ante, cons)
`define SLFD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* hdl/slfd_pkg.sv */
package slfd_pkg;

    localparam int ByteW   = 8;
    localparam int TickW   = 32;
    localparam int StatusW = 2;
    localparam int CheckW  = 16;
    localparam int CfgIdxW = 2;
    localparam int InDataW  = 40;
    localparam int OutDataW = 40;
    localparam int OutUserW = 3;

    typedef logic [StatusW-1:0] status_t;
    localparam status_t ST_INCOMPLETE = 2'd0;
    localparam status_t ST_COMPLETE   = 2'd1;
    localparam status_t ST_ERROR      = 2'd2;
    localparam status_t ST_TIMEOUT    = 2'd3;

    typedef logic [CfgIdxW-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_FIRST_SYNC    = 2'd0;
    localparam cfg_idx_t CFG_SECOND_SYNC   = 2'd1;
    localparam cfg_idx_t CFG_MAX_LENGTH    = 2'd2;
    localparam cfg_idx_t CFG_TIMEOUT_TICKS = 2'd3;

    localparam logic [ByteW-1:0] FIRST_SYNC_RST  = 8'hAA;
    localparam logic [ByteW-1:0] SECOND_SYNC_RST = 8'h55;
    localparam logic [ByteW-1:0] MAX_LENGTH_RST  = 8'd128;
    localparam logic [TickW-1:0] TIMEOUT_RST     = 32'd1000;

endpackage

/* hdl/sync_length_frame_deframer_unit.sv */
// latency: an accepted request's result is registered and shows on m_* in the next cycle
// one request per cycle unless m_tready stalls; the frame FSM updates in one step
// s_tready stays high while the result register is empty or being drained this cycle
// reset: aresetn is synchronous, active low; clears the frame state and the result valid
// reset also restores the registers to first_sync 0xAA, second_sync 0x55,
// max_length 128 and timeout_ticks 1000
`include "sync_length_frame_deframer_unit_macros.svh"

module sync_length_frame_deframer_unit
    import slfd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [TickW-1:0]    cfg_wdata,
    // byte input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // rx_byte[7:0], now_tick[39:8]
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // payload_byte[7:0], payload_index[15:8],
                                           // frame_length[23:16], check_value[39:24]
    output logic [OutUserW-1:0] m_tuser    // status[1:0], payload_valid[2]
);

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHK_HI  = 3'd4,
        PH_CHK_LO  = 3'd5
    } phase_t;

    // configuration registers
    logic [ByteW-1:0] first_sync_reg;
    logic [ByteW-1:0] second_sync_reg;
    logic [ByteW-1:0] max_length_reg;
    logic [TickW-1:0] timeout_ticks_reg;

    // frame state
    phase_t           phase_reg,      phase_next;
    logic [TickW-1:0] start_tick_reg, start_tick_next;
    logic [ByteW-1:0] length_reg,     length_next;
    logic [ByteW-1:0] position_reg,   position_next;
    logic [ByteW-1:0] check_hi_reg,   check_hi_next;

    // result register
    logic              m_valid_reg;
    status_t           status_reg,    status_next;
    logic              pvalid_reg,    pvalid_next;
    logic [ByteW-1:0]  pbyte_reg,     pbyte_next;
    logic [ByteW-1:0]  pindex_reg,    pindex_next;
    logic [ByteW-1:0]  flen_reg,      flen_next;
    logic [CheckW-1:0] check_reg,     check_next;

    logic             s_accept;
    logic [ByteW-1:0] rx_byte;
    logic [TickW-1:0] now_tick;
    logic [TickW-1:0] elapsed;
    logic             timed_out;
    logic [ByteW-1:0] position_inc;

    assign rx_byte  = s_tdata[ByteW-1:0];
    assign now_tick = s_tdata[ByteW +: TickW];

    // the result register frees up in the same cycle it is taken
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // modular elapsed time since the first sync byte
    assign elapsed      = now_tick - start_tick_reg;
    assign timed_out    = (phase_reg != PH_HUNT1) && (elapsed > timeout_ticks_reg);
    assign position_inc = position_reg + 8'd1;

    // one-step frame state machine
    always_comb begin
        phase_next      = phase_reg;
        start_tick_next = start_tick_reg;
        length_next     = length_reg;
        position_next   = position_reg;
        check_hi_next   = check_hi_reg;
        status_next     = ST_INCOMPLETE;
        pvalid_next     = 1'b0;
        pbyte_next      = '0;
        pindex_next     = '0;
        check_next      = '0;
        flen_next       = '0;

        if (timed_out) begin
            // drop the byte, abandon the frame
            phase_next      = PH_HUNT1;
            start_tick_next = '0;
            length_next     = '0;
            position_next   = '0;
            check_hi_next   = '0;
            status_next     = ST_TIMEOUT;
        end else begin
            case (phase_reg)
                PH_HUNT1: begin
                    if (rx_byte == first_sync_reg) begin
                        phase_next      = PH_HUNT2;
                        start_tick_next = now_tick;
                    end
                end
                PH_HUNT2: begin
                    // mismatch goes back to hunting without re-checking this byte
                    phase_next = (rx_byte == second_sync_reg) ? PH_LENGTH : PH_HUNT1;
                end
                PH_LENGTH: begin
                    if (rx_byte > max_length_reg) begin
                        phase_next      = PH_HUNT1;
                        start_tick_next = '0;
                        length_next     = '0;
                        position_next   = '0;
                        check_hi_next   = '0;
                        status_next     = ST_ERROR;
                    end else begin
                        length_next   = rx_byte;
                        position_next = '0;
                        // zero length skips straight to the check bytes
                        phase_next    = (rx_byte == '0) ? PH_CHK_HI : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    pvalid_next   = 1'b1;
                    pbyte_next    = rx_byte;
                    pindex_next   = position_reg;
                    position_next = position_inc;
                    if (position_inc >= length_reg || position_inc == '0) begin
                        phase_next = PH_CHK_HI;
                    end
                end
                PH_CHK_HI: begin
                    check_hi_next = rx_byte;
                    phase_next    = PH_CHK_LO;
                end
                PH_CHK_LO: begin
                    check_next  = {check_hi_reg, rx_byte};
                    phase_next  = PH_HUNT1;
                    status_next = ST_COMPLETE;
                end
                default: begin
                    // unreachable phase code: recover through a reset
                    phase_next      = PH_HUNT1;
                    start_tick_next = '0;
                    length_next     = '0;
                    position_next   = '0;
                    check_hi_next   = '0;
                    status_next     = ST_ERROR;
                end
            endcase
        end

        // a rejected length byte is reported as received
        if (!timed_out && phase_reg == PH_LENGTH && rx_byte > max_length_reg) begin
            flen_next = rx_byte;
        end else begin
            flen_next = length_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_sync_reg    <= FIRST_SYNC_RST;
            second_sync_reg   <= SECOND_SYNC_RST;
            max_length_reg    <= MAX_LENGTH_RST;
            timeout_ticks_reg <= TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FIRST_SYNC:    first_sync_reg    <= cfg_wdata[ByteW-1:0];
                CFG_SECOND_SYNC:   second_sync_reg   <= cfg_wdata[ByteW-1:0];
                CFG_MAX_LENGTH:    max_length_reg    <= cfg_wdata[ByteW-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // frame state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT1;
            start_tick_reg <= '0;
            length_reg     <= '0;
            position_reg   <= '0;
            check_hi_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg      <= phase_next;
                start_tick_reg <= start_tick_next;
                length_reg     <= length_next;
                position_reg   <= position_next;
                check_hi_reg   <= check_hi_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            status_reg <= status_next;
            pvalid_reg <= pvalid_next;
            pbyte_reg  <= pbyte_next;
            pindex_reg <= pindex_next;
            flen_reg   <= flen_next;
            check_reg  <= check_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {check_reg, flen_reg, pindex_reg, pbyte_reg};
    assign m_tuser  = {pvalid_reg, status_reg};

    // payload bytes always carry an incomplete status
    `SLFD_ASSERT_NOW(a_payload_status, aclk, aresetn, m_valid_reg && pvalid_reg, status_reg == ST_INCOMPLETE)
    // inside the payload the index stays below the stored length
    `SLFD_ASSERT_NOW(a_position_bound, aclk, aresetn, phase_reg == PH_PAYLOAD, position_reg < length_reg)
    // an accepted request always leaves a result waiting
    `SLFD_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_accept, m_valid_reg)
    // a first sync byte while hunting always opens a frame
    `SLFD_ASSERT_NEXT(a_sync_opens, aclk, aresetn, s_accept && phase_reg == PH_HUNT1 && rx_byte == first_sync_reg, phase_reg == PH_HUNT2)

endmodule
